[design/kepler_newton_solver_core_macros.svh]
// Assertion macros for the Kepler solver core.
`ifndef KEPLER_NEWTON_SOLVER_CORE_MACROS_SVH
`define KEPLER_NEWTON_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KNS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kns assertion failed");

// Next-cycle implication, checked outside reset
`define KNS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kns assertion failed");

`endif

[design/kns_pkg.sv]
// ----------------------------------------------------------------------------
// kns_pkg
// Types, constants and the CORDIC angle table of the Kepler solver core.
// ----------------------------------------------------------------------------
`default_nettype none

package kns_pkg;

  localparam int FRACTION_BITS = 29;
  localparam int WORK_BITS     = 60;
  localparam int CORDIC_STEPS  = 60;
  localparam int GUARD_BITS    = 30;
  localparam int SIN_SHIFT     = 2 * WORK_BITS - 28 - FRACTION_BITS - GUARD_BITS;
  localparam int COS_SHIFT     = 31;
  localparam int DIV_STEPS     = 34;
  localparam int MAX_LIMIT     = 64;

  localparam logic signed [63:0] PI_W       = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] TWO_PI_W   = 64'sh6487ED5110B4611A;
  localparam logic signed [63:0] HALF_PI_W  = PI_W >>> 1;
  localparam logic signed [63:0] INV_GAIN_W = 64'sd700114967507363238;
  localparam logic signed [63:0] ONE_Q61    = 64'sh2000000000000000;
  localparam logic [63:0] TURN_W      = 64'h6487ED5110B4611A >> (WORK_BITS - FRACTION_BITS);
  localparam logic [63:0] HALF_TURN_W = TURN_W >> 1;

  // register indexes of the configuration port
  localparam logic REG_MAX_ITER  = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  typedef logic signed [63:0] angle_tab_t [CORDIC_STEPS];

  typedef enum logic [4:0] {
    ST_IDLE, ST_TURN, ST_WRAP, ST_FOLD, ST_ROT, ST_SIGN,
    ST_MUL_SL, ST_MUL_SH, ST_SCL_S, ST_MUL_CL, ST_MUL_CH, ST_SCL_C,
    ST_FORM, ST_DCHK, ST_DIV, ST_UPD, ST_CHK, ST_DONE
  } kns_state_t;

  // long division of a constant by a small divisor, used at elaboration
  function automatic logic [63:0] kns_div_small(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], a[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent series of 2^-i in Q60, built at elaboration
  function automatic angle_tab_t kns_angles();
    angle_tab_t t;
    logic signed [63:0] acc;
    logic signed [63:0] term;
    t[0] = PI_W >>> 2;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      acc = '0;
      for (int k = 0; i * (2 * k + 1) <= WORK_BITS; k++) begin
        term = $signed(kns_div_small(64'd1 << (WORK_BITS - i * (2 * k + 1)),
                                     64'(2 * k + 1)));
        acc  = k[0] ? acc - term : acc + term;
      end
      t[i] = acc;
    end
    return t;
  endfunction

  localparam angle_tab_t ANGLE_TAB = kns_angles();

endpackage

`default_nettype wire

[design/kns_req_if.sv]
// ----------------------------------------------------------------------------
// kns_req_if
// Input channel: mean anomaly and eccentricity.
// ----------------------------------------------------------------------------
`default_nettype none

interface kns_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_anomaly;
  logic        [31:0] eccentricity;

  modport source (output valid, output mean_anomaly, output eccentricity, input ready);
  modport sink   (input valid, input mean_anomaly, input eccentricity, output ready);
endinterface

`default_nettype wire

[design/kns_rsp_if.sv]
// ----------------------------------------------------------------------------
// kns_rsp_if
// Result channel: eccentric anomaly, step count and converged flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface kns_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eccentric_anomaly;
  logic        [6:0]  iterations_used;
  logic               converged;

  modport source (output valid, output eccentric_anomaly, output iterations_used,
                  output converged, input ready);
  modport sink   (input valid, input eccentric_anomaly, input iterations_used,
                  input converged, output ready);
endinterface

`default_nettype wire

[design/kepler_newton_solver_core.sv]
// ----------------------------------------------------------------------------
// kepler_newton_solver_core
// Newton solver for M = E - e*sin(E) with a shared CORDIC, multiplier and
// restoring divider under one sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  beat fields
//  req       in   mean_anomaly, eccentricity
//  rsp       out  eccentric_anomaly, iterations_used, converged
//  cfg       in   cfg_index (0 max_iterations, 1 tolerance), cfg_data
//
//  A Newton step runs angle reduction, CORDIC rotation, the two eccentricity
//  products, form, range check, division (skipped when the quotient
//  saturates) and update. An item passes through idle, its full steps and
//  done.
//  req.ready is high only while idle; a finished result waits in the output
//  register while a new item is taken. Reset is synchronous and sets the
//  registers to 8 steps and tolerance 537.
`default_nettype none
`include "kepler_newton_solver_core_macros.svh"

module kepler_newton_solver_core (
  input  wire logic        clk,
  input  wire logic        rst,
  kns_req_if.sink          req,
  kns_rsp_if.source        rsp,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data
);

  kns_pkg::kns_state_t state, state_next;

  logic [6:0]  max_iter;
  logic [30:0] tol;

  logic signed [31:0] m, est, est_new;
  logic        [31:0] ecc;
  logic        [6:0]  lim, used;
  logic signed [63:0] x, y, z;
  logic               flip;
  logic        [5:0]  cnt;
  logic        [63:0] usin, ucos;
  logic               nsin, ncos;
  logic        [63:0] plo, phi;
  logic signed [63:0] ps, pc, num, den;
  logic        [66:0] rem;
  logic        [34:0] quo;
  logic               conv;
  logic               out_valid;
  logic signed [31:0] out_est;
  logic        [6:0]  out_used;
  logic               out_conv;

  logic accept;
  assign accept = req.valid && req.ready;

  // shared 32x32 multiplier
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  always_comb begin
    unique case (state)
      kns_pkg::ST_MUL_SL: mul_a = usin[31:0];
      kns_pkg::ST_MUL_SH: mul_a = usin[63:32];
      kns_pkg::ST_MUL_CL: mul_a = ucos[31:0];
      default:            mul_a = ucos[63:32];
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, ecc};

  // join partial products and scale
  logic [95:0] full_p;
  logic [63:0] sc_sin, sc_cos;
  assign full_p = {phi, 32'd0} + {32'd0, plo};
  assign sc_sin = 64'(full_p >> kns_pkg::SIN_SHIFT);
  assign sc_cos = 64'(full_p >> kns_pkg::COS_SHIFT);

  // angle reduction terms
  logic [32:0]        ang_mag;
  logic               turn;
  logic signed [63:0] ang_w;
  assign ang_mag = est[31] ? (33'd0 - {est[31], est}) : {1'b0, est};
  assign turn    = ({31'd0, ang_mag} + kns_pkg::HALF_TURN_W) >= kns_pkg::TURN_W;
  assign ang_w   = 64'(est) <<< (kns_pkg::WORK_BITS - kns_pkg::FRACTION_BITS);

  // divider trial
  logic [66:0] trial, cmpv;
  logic [63:0] nmag;
  assign nmag  = num[63] ? (64'd0 - num) : num;
  assign trial = (cnt < 6'd3) ? rem : {rem[65:0], 1'b0};
  assign cmpv  = (cnt < 6'd3) ? ({3'd0, den} << (2'd2 - cnt[1:0])) : {3'd0, den};

  // update terms
  logic signed [36:0] upd, est_w;
  logic signed [32:0] diff_s;
  logic        [32:0] diff;
  logic        [6:0]  used_inc;
  assign est_w    = 37'(est);
  assign upd      = num[63] ? est_w + $signed({2'b0, quo}) : est_w - $signed({2'b0, quo});
  assign diff_s   = 33'(est_new) - 33'(est);
  assign diff     = diff_s[32] ? (33'd0 - diff_s) : diff_s;
  assign used_inc = used + 7'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= 7'd8;
      tol      <= 31'd537;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kns_pkg::REG_MAX_ITER:  max_iter <= cfg_data[6:0];
        kns_pkg::REG_TOLERANCE: tol      <= cfg_data;
        default:                tol      <= tol;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kns_pkg::ST_IDLE:   if (accept) state_next = kns_pkg::ST_TURN;
      kns_pkg::ST_TURN:   state_next = kns_pkg::ST_WRAP;
      kns_pkg::ST_WRAP:   state_next = kns_pkg::ST_FOLD;
      kns_pkg::ST_FOLD:   state_next = kns_pkg::ST_ROT;
      kns_pkg::ST_ROT:
        if (cnt == 6'(kns_pkg::CORDIC_STEPS - 1)) state_next = kns_pkg::ST_SIGN;
      kns_pkg::ST_SIGN:   state_next = kns_pkg::ST_MUL_SL;
      kns_pkg::ST_MUL_SL: state_next = kns_pkg::ST_MUL_SH;
      kns_pkg::ST_MUL_SH: state_next = kns_pkg::ST_SCL_S;
      kns_pkg::ST_SCL_S:  state_next = kns_pkg::ST_MUL_CL;
      kns_pkg::ST_MUL_CL: state_next = kns_pkg::ST_MUL_CH;
      kns_pkg::ST_MUL_CH: state_next = kns_pkg::ST_SCL_C;
      kns_pkg::ST_SCL_C:  state_next = kns_pkg::ST_FORM;
      kns_pkg::ST_FORM:   state_next = kns_pkg::ST_DCHK;
      kns_pkg::ST_DCHK:
        state_next = ({3'd0, nmag} >= {den, 3'd0}) ? kns_pkg::ST_UPD : kns_pkg::ST_DIV;
      kns_pkg::ST_DIV:
        if (cnt == 6'(kns_pkg::DIV_STEPS - 1)) state_next = kns_pkg::ST_UPD;
      kns_pkg::ST_UPD:    state_next = kns_pkg::ST_CHK;
      kns_pkg::ST_CHK:
        state_next = (diff <= {2'd0, tol} || used_inc == lim) ?
                     kns_pkg::ST_DONE : kns_pkg::ST_TURN;
      kns_pkg::ST_DONE:
        if (!out_valid || rsp.ready) state_next = kns_pkg::ST_IDLE;
      default:            state_next = kns_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req.ready             = (state == kns_pkg::ST_IDLE);
    rsp.valid             = out_valid;
    rsp.eccentric_anomaly = out_est;
    rsp.iterations_used   = out_used;
    rsp.converged         = out_conv;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kns_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == kns_pkg::ST_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      kns_pkg::ST_IDLE: begin
        if (accept) begin
          m    <= req.mean_anomaly;
          est  <= req.mean_anomaly;
          ecc  <= req.eccentricity;
          used <= '0;
          if (max_iter == 7'd0) lim <= 7'd1;
          else if (max_iter > 7'(kns_pkg::MAX_LIMIT)) lim <= 7'(kns_pkg::MAX_LIMIT);
          else lim <= max_iter;
        end
      end
      kns_pkg::ST_TURN: begin
        if (!turn) z <= ang_w;
        else if (est[31]) z <= ang_w + kns_pkg::TWO_PI_W;
        else z <= ang_w - kns_pkg::TWO_PI_W;
      end
      kns_pkg::ST_WRAP: begin
        if (z > kns_pkg::PI_W) z <= z - kns_pkg::TWO_PI_W;
        else if (z < -kns_pkg::PI_W) z <= z + kns_pkg::TWO_PI_W;
      end
      kns_pkg::ST_FOLD: begin
        // fold into the right half plane, negating sin and cos afterward
        if (z > kns_pkg::HALF_PI_W) begin
          z    <= z - kns_pkg::PI_W;
          flip <= 1'b1;
        end else if (z < -kns_pkg::HALF_PI_W) begin
          z    <= z + kns_pkg::PI_W;
          flip <= 1'b1;
        end else begin
          flip <= 1'b0;
        end
        x   <= kns_pkg::INV_GAIN_W;
        y   <= '0;
        cnt <= '0;
      end
      kns_pkg::ST_ROT: begin
        if (z >= 0) begin
          x <= x - (y >>> cnt);
          y <= y + (x >>> cnt);
          z <= z - kns_pkg::ANGLE_TAB[cnt];
        end else begin
          x <= x + (y >>> cnt);
          y <= y - (x >>> cnt);
          z <= z + kns_pkg::ANGLE_TAB[cnt];
        end
        cnt <= cnt + 6'd1;
      end
      kns_pkg::ST_SIGN: begin
        usin <= y[63] ? (64'd0 - y) : y;
        ucos <= x[63] ? (64'd0 - x) : x;
        nsin <= flip ? (y > 0) : y[63];
        ncos <= flip ? (x > 0) : x[63];
      end
      kns_pkg::ST_MUL_SL, kns_pkg::ST_MUL_CL: plo <= mul_p;
      kns_pkg::ST_MUL_SH, kns_pkg::ST_MUL_CH: phi <= mul_p;
      kns_pkg::ST_SCL_S: ps <= nsin ? $signed(64'd0 - sc_sin) : $signed(sc_sin);
      kns_pkg::ST_SCL_C: pc <= ncos ? $signed(64'd0 - sc_cos) : $signed(sc_cos);
      kns_pkg::ST_FORM: begin
        num <= ((64'(est) - 64'(m)) <<< kns_pkg::GUARD_BITS) - ps;
        if (kns_pkg::ONE_Q61 - pc < 64'sd1) den <= 64'sd1;
        else den <= kns_pkg::ONE_Q61 - pc;
      end
      kns_pkg::ST_DCHK: begin
        rem <= {3'd0, nmag};
        cnt <= '0;
        if ({3'd0, nmag} >= {den, 3'd0}) quo <= 35'(64'd1 << kns_pkg::DIV_STEPS);
        else quo <= '0;
      end
      kns_pkg::ST_DIV: begin
        if (trial >= cmpv) begin
          rem <= trial - cmpv;
          quo <= {quo[33:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[33:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
      end
      kns_pkg::ST_UPD: begin
        // saturate the new estimate to 32 bits
        if (upd > 37'sh07FFFFFFF) est_new <= 32'sh7FFFFFFF;
        else if (upd < -37'sh080000000) est_new <= 32'sh80000000;
        else est_new <= upd[31:0];
      end
      kns_pkg::ST_CHK: begin
        est  <= est_new;
        used <= used_inc;
        conv <= (diff <= {2'd0, tol});
      end
      kns_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_est  <= est;
          out_used <= used;
          out_conv <= conv;
        end
      end
      default: begin
      end
    endcase
  end

  `KNS_ASSERT_IMP(a_used_range, clk, rst, out_valid, (out_used != 7'd0) && (out_used <= 7'd64))
  `KNS_ASSERT_IMP(a_rot_count, clk, rst, state == kns_pkg::ST_ROT, cnt <= 6'd59)
  `KNS_ASSERT_NXT(a_accept_busy, clk, rst, accept, !req.ready)
  `KNS_ASSERT_IMP(a_used_limit, clk, rst, state == kns_pkg::ST_DONE, (used <= lim) && (conv || used == lim))

endmodule

`default_nettype wire
